FILE: rtl/rrs_pkg.sv
// rrs_pkg: shared types and constants of the round-robin job scheduler
// depends on: nothing
`timescale 1ns / 1ps

package rrs_pkg;

	// table geometry
	localparam int MAX_JOBS = 8;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);

	// field widths
	localparam int ID_W    = 8;
	localparam int TIME_W  = 16;
	localparam int CLOCK_W = 24;
	localparam int SUM_W   = 32;

	// command modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// one table entry as stored in the job memory
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_EXEC = 7'b0000100,
		ST_NEXT = 7'b0001000,
		ST_WAIT = 7'b0010000,
		ST_ACC  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	// saturating sum of two totals
	function automatic logic [SUM_W-1:0] add_sat32(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

FILE: rtl/rrs_cmd_if.sv
// rrs_cmd_if: command channel of the scheduler (load a job or run a step)
// depends on: rrs_pkg
`timescale 1ns / 1ps

interface rrs_cmd_if import rrs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ID_W-1:0]   job_id;
	logic [TIME_W-1:0] arrival_time;
	logic [TIME_W-1:0] burst_time;

	modport source (output valid, mode, job_id, arrival_time, burst_time, input ready);
	modport sink (input valid, mode, job_id, arrival_time, burst_time, output ready);
endinterface

FILE: rtl/rrs_rsp_if.sv
// rrs_rsp_if: result channel of the scheduler, one word per step
// depends on: rrs_pkg
`timescale 1ns / 1ps

interface rrs_rsp_if import rrs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    served_id;
	logic [CLOCK_W-1:0] slice_end;
	logic               served;
	logic               job_finished;
	logic               all_done;
	logic [SUM_W-1:0]   total_wait;
	logic [SUM_W-1:0]   total_turnaround;

	modport source (output valid, served_id, slice_end, served, job_finished, all_done,
		total_wait, total_turnaround, input ready);
	modport sink (input valid, served_id, slice_end, served, job_finished, all_done,
		total_wait, total_turnaround, output ready);
endinterface

FILE: rtl/rrs_ram.sv
// rrs_ram: generic simple dual-port RAM, one write and one registered read port
// depends on: nothing
`timescale 1ns / 1ps

module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/round_robin_scheduler.sv
// round_robin_scheduler: round-robin job scheduler with a fixed quantum
// depends on: rrs_pkg, rrs_cmd_if, rrs_rsp_if, rrs_ram
`timescale 1ns / 1ps

// Usage
// cmd carries one word per command. mode load appends a job (id, arrival,
// burst) to a table of MAX_JOBS entries held in a one-port-read RAM; a load
// into a full table is dropped. A load gives no result: ready stays high,
// so loads can follow back to back.
// mode step serves one job and always returns one word on rsp: served id,
// slice end time, served/finished/all-done flags and the running totals.
// A step walks the table from the current entry one RAM read per cycle until
// it finds an arrived job with work; when none has arrived it serves the
// earliest arrival and moves the clock up to it. After the scan the step
// passes EXEC and NEXT, then WAIT and ACC when the job completes (wait and
// turnaround totals), then OUT, which loads the output register. cmd is not
// ready again until the step is back in idle; an empty step serves no job
// and goes straight from idle to OUT.
// quantum is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while idle (not enforced here). It resets to 4 and 0 acts as 1.
// arst_n clears the table count, done flags, clock and totals; table
// contents are not cleared. While rsp is stalled the finished word waits in
// the output register and cmd can still take a command; the next step
// result waits until the register frees.

module round_robin_scheduler import rrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TIME_W-1:0] cfg_wr_data,
	rrs_cmd_if.sink           cmd,
	rrs_rsp_if.source         rsp
);

	state_t              state_q;
	logic [TIME_W-1:0]   quantum_q;
	logic [CNT_W-1:0]    job_count_q;
	logic [CNT_W-1:0]    unfinished_q;
	logic [IDX_W-1:0]    cur_idx_q;
	logic [CLOCK_W-1:0]  clock_q;
	logic [SUM_W-1:0]    wait_sum_q;
	logic [SUM_W-1:0]    turn_sum_q;
	logic [MAX_JOBS-1:0] done_q;

	// scan and selected-entry registers
	logic [IDX_W-1:0]    j_q;
	logic [CNT_W-1:0]    k_q;
	logic                best_found_q;
	logic [IDX_W-1:0]    best_idx_q;
	entry_t              best_q;
	entry_t              sel_q;
	logic [IDX_W-1:0]    sel_idx_q;
	logic                served_q;
	logic                fin_q;
	logic [CLOCK_W-1:0]  t_q;
	logic [CLOCK_W-1:0]  w_q;

	// output register
	logic                rsp_valid_q;
	logic [ID_W-1:0]     rsp_id_q;
	logic [CLOCK_W-1:0]  rsp_end_q;
	logic                rsp_served_q;
	logic                rsp_fin_q;
	logic                rsp_all_q;
	logic [SUM_W-1:0]    rsp_wait_q;
	logic [SUM_W-1:0]    rsp_turn_q;

	// memory port signals
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	entry_t              mem_wdata;
	logic [IDX_W-1:0]    mem_raddr;
	logic [ENTRY_W-1:0]  mem_rdata;
	entry_t              rd;

	logic                cmd_acc;
	logic [IDX_W-1:0]    cur;
	logic [IDX_W-1:0]    next_j;
	logic                hit;
	logic                take;
	logic                scan_last;
	logic [TIME_W-1:0]   q_eff;
	logic                fin_c;
	logic [TIME_W-1:0]   adv;
	logic [CLOCK_W:0]    clk_sum;
	logic [CLOCK_W-1:0]  clock_new;
	logic [CNT_W-1:0]    succ;
	logic                out_free;

	assign rd        = entry_t'(mem_rdata);
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// starting entry of a step
	assign cur = ({1'b0, cur_idx_q} < job_count_q) ? cur_idx_q : '0;

	// cyclic successor during the scan
	always_comb begin
		if (CNT_W'(j_q) + CNT_W'(1) == job_count_q) begin
			next_j = '0;
		end else begin
			next_j = j_q + IDX_W'(1);
		end
	end

	// scan decisions on the word read for entry j_q
	assign hit  = !done_q[j_q] && ({8'b0, rd.arrival} <= clock_q);
	assign take = !done_q[j_q] && (!best_found_q || rd.arrival < best_q.arrival ||
		(rd.arrival == best_q.arrival && j_q < best_idx_q));
	assign scan_last = (k_q + CNT_W'(1) == job_count_q);

	// slice arithmetic
	assign q_eff     = (quantum_q == '0) ? TIME_W'(1) : quantum_q;
	assign fin_c     = (sel_q.remaining <= q_eff);
	assign adv       = fin_c ? sel_q.remaining : q_eff;
	assign clk_sum   = {1'b0, clock_q} + (CLOCK_W + 1)'(adv);
	assign clock_new = clk_sum[CLOCK_W] ? {CLOCK_W{1'b1}} : clk_sum[CLOCK_W-1:0];
	assign succ      = CNT_W'(sel_idx_q) + CNT_W'(1);

	// memory port muxing
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = job_count_q[IDX_W-1:0];
		mem_wdata = '{id: cmd.job_id, arrival: cmd.arrival_time,
			burst: cmd.burst_time, remaining: cmd.burst_time};
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				mem_we    = cmd_acc && cmd.mode == MODE_LOAD &&
					job_count_q < CNT_W'(MAX_JOBS);
				mem_raddr = cur;
			end
			ST_SCAN: begin
				mem_raddr = next_j;
			end
			ST_EXEC: begin
				mem_we    = 1'b1;
				mem_waddr = sel_idx_q;
				mem_wdata = sel_q;
				mem_wdata.remaining = fin_c ? '0 : sel_q.remaining - q_eff;
				mem_raddr = succ[IDX_W-1:0];
			end
			default: begin
				mem_raddr = '0;
			end
		endcase
	end

	rrs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_JOBS)
	) u_job_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= TIME_W'(4);
		end else if (cfg_wr_en) begin
			quantum_q <= cfg_wr_data;
		end
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			job_count_q  <= '0;
			unfinished_q <= '0;
			cur_idx_q    <= '0;
			clock_q      <= '0;
			wait_sum_q   <= '0;
			turn_sum_q   <= '0;
			done_q       <= '0;
			best_found_q <= 1'b0;
			served_q     <= 1'b0;
			fin_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd.mode == MODE_LOAD) begin
							// append a job unless the table is full
							if (job_count_q < CNT_W'(MAX_JOBS)) begin
								done_q[job_count_q[IDX_W-1:0]] <= (cmd.burst_time == '0);
								if (cmd.burst_time != '0) begin
									unfinished_q <= unfinished_q + CNT_W'(1);
								end
								job_count_q <= job_count_q + CNT_W'(1);
							end
						end else if (unfinished_q == '0) begin
							// nothing left: report the current state
							served_q <= 1'b0;
							fin_q    <= 1'b0;
							state_q  <= ST_OUT;
						end else begin
							j_q          <= cur;
							k_q          <= '0;
							best_found_q <= 1'b0;
							state_q      <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						sel_q     <= rd;
						sel_idx_q <= j_q;
						state_q   <= ST_EXEC;
					end else if (scan_last) begin
						// idle jump to the earliest pending arrival
						if (take) begin
							sel_q     <= rd;
							sel_idx_q <= j_q;
							clock_q   <= CLOCK_W'(rd.arrival);
						end else begin
							sel_q     <= best_q;
							sel_idx_q <= best_idx_q;
							clock_q   <= CLOCK_W'(best_q.arrival);
						end
						state_q <= ST_EXEC;
					end else begin
						if (take) begin
							best_q       <= rd;
							best_idx_q   <= j_q;
							best_found_q <= 1'b1;
						end
						j_q <= next_j;
						k_q <= k_q + CNT_W'(1);
					end
				end
				ST_EXEC: begin
					clock_q  <= clock_new;
					served_q <= 1'b1;
					fin_q    <= fin_c;
					if (fin_c) begin
						done_q[sel_idx_q] <= 1'b1;
						unfinished_q      <= unfinished_q - CNT_W'(1);
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					// successor becomes current only if it has arrived
					if (succ < job_count_q && {8'b0, rd.arrival} <= clock_q) begin
						cur_idx_q <= succ[IDX_W-1:0];
					end else begin
						cur_idx_q <= '0;
					end
					t_q     <= (clock_q >= CLOCK_W'(sel_q.arrival)) ?
						clock_q - CLOCK_W'(sel_q.arrival) : '0;
					state_q <= fin_q ? ST_WAIT : ST_OUT;
				end
				ST_WAIT: begin
					w_q        <= (t_q >= CLOCK_W'(sel_q.burst)) ?
						t_q - CLOCK_W'(sel_q.burst) : '0;
					turn_sum_q <= add_sat32(turn_sum_q, SUM_W'(t_q));
					state_q    <= ST_ACC;
				end
				ST_ACC: begin
					wait_sum_q <= add_sat32(wait_sum_q, SUM_W'(w_q));
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			rsp_id_q     <= served_q ? sel_q.id : '0;
			rsp_end_q    <= clock_q;
			rsp_served_q <= served_q;
			rsp_fin_q    <= fin_q;
			rsp_all_q    <= (unfinished_q == '0);
			rsp_wait_q   <= wait_sum_q;
			rsp_turn_q   <= turn_sum_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.served_id        = rsp_id_q;
	assign rsp.slice_end        = rsp_end_q;
	assign rsp.served           = rsp_served_q;
	assign rsp.job_finished     = rsp_fin_q;
	assign rsp.all_done         = rsp_all_q;
	assign rsp.total_wait       = rsp_wait_q;
	assign rsp.total_turnaround = rsp_turn_q;

endmodule
